// ===== design/pcpd_pkg.sv =====
// ============================================================================
// pcpd_pkg: shared types and constants of the column post decoder
// Field widths, command codes, register indexes and the phase encoding.
// ============================================================================
`default_nettype none

package pcpd_pkg;

    // Default geometry and scale limit.
    localparam int DEF_SCREEN_HEIGHT = 256;
    localparam int DEF_SCREEN_WIDTH  = 512;
    localparam int DEF_MAX_SCALE     = 8;

    // Field widths.
    localparam int CMD_W    = 1;
    localparam int SCR_W    = 3;
    localparam int COLX_W   = 9;
    localparam int ROWY_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int WADDR_W  = 17;
    localparam int SCALE_W  = 4;
    localparam int SUB_W    = 3;   // block cell counter, covers scale up to 8
    localparam int SUM_W    = 9;   // post top plus pixel offset
    localparam int ROW_W    = 13;  // top row + 510 * 8 + 7 fits
    localparam int COL_W    = 10;  // column x + 7 fits

    // Configuration port.
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic [PADDR_W-3:0] REG_SCALE = 1'b0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_START = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DATA  = 1'b1;

    localparam logic [BYTE_W-1:0] END_MARK = 8'hff;

    // Decoder phase, one-hot.
    typedef enum logic [5:0] {
        PH_WAIT = 6'b000001,
        PH_TOP  = 6'b000010,
        PH_LEN  = 6'b000100,
        PH_PAD1 = 6'b001000,
        PH_PIX  = 6'b010000,
        PH_PAD2 = 6'b100000
    } phase_t;

endpackage

`default_nettype wire

// ===== design/patch_column_post_decoder_unit.sv =====
// ============================================================================
// patch_column_post_decoder_unit: sprite column post decoder
// Turns a stream of start commands and column bytes into scaled
// framebuffer writes.
// ============================================================================
//
// Usage
//   The input channel carries one command or column byte per transfer. A
//   start command latches screen, column x and top y; data bytes then walk
//   through the posts of the column. Each pixel byte produces scale * scale
//   write transfers on the output channel, column by column, top to bottom,
//   with last set on the final one. Other bytes produce no output.
//   The scale register sits at byte address 0 of the APB port.
//   A pixel byte is registered in the write generator, whose first write
//   then moves to the output register. Non-pixel bytes are taken one per
//   cycle while no job runs; a pixel byte holds the input until its block
//   is done, as the generator emits one write per cycle while the output
//   is free; the next pixel goes in the cycle the last write is registered.
//   A stall on the output freezes the output register and the generator,
//   which in turn stalls the input. Reset returns the decoder to waiting
//   for a start command, empties both stages and sets scale to 1.
//
`default_nettype none

module patch_column_post_decoder_unit #(
    parameter int SCREEN_HEIGHT = pcpd_pkg::DEF_SCREEN_HEIGHT,
    parameter int SCREEN_WIDTH  = pcpd_pkg::DEF_SCREEN_WIDTH,
    parameter int MAX_SCALE     = pcpd_pkg::DEF_MAX_SCALE
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcpd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pcpd_pkg::PDATA_W-1:0]  pwdata,
    output logic      [pcpd_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [pcpd_pkg::CMD_W-1:0]    command,
    input  wire logic [pcpd_pkg::SCR_W-1:0]    screen_index,
    input  wire logic [pcpd_pkg::COLX_W-1:0]   column_x,
    input  wire logic [pcpd_pkg::ROWY_W-1:0]   column_top_y,
    input  wire logic [pcpd_pkg::BYTE_W-1:0]   data_byte,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [pcpd_pkg::SCR_W-1:0]    target_screen,
    output logic      [pcpd_pkg::WADDR_W-1:0]  write_address,
    output logic      [pcpd_pkg::BYTE_W-1:0]   pixel,
    output logic                               out_of_range,
    output logic                               last
);
    import pcpd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [SCALE_W-1:0] scale_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            scale_reg <= pwdata[SCALE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_SCALE)
        begin
            prdata = PDATA_W'(scale_reg);
        end
    end

    // Effective scale, clamped to 1..MAX_SCALE.
    logic [SCALE_W-1:0] eff_scale;

    always_comb
    begin
        if (scale_reg == '0)
        begin
            eff_scale = SCALE_W'(1);
        end
        else if (scale_reg > SCALE_W'(MAX_SCALE))
        begin
            eff_scale = SCALE_W'(MAX_SCALE);
        end
        else
        begin
            eff_scale = scale_reg;
        end
    end

    // ------------------------------------------------------------------
    // Post parser
    // ------------------------------------------------------------------
    phase_t             phase_reg,        phase_next;
    logic [COLX_W-1:0]  base_column_reg,  base_column_next;
    logic [ROWY_W-1:0]  top_row_reg,      top_row_next;
    logic [SCR_W-1:0]   screen_sel_reg,   screen_sel_next;
    logic [BYTE_W-1:0]  post_top_reg,     post_top_next;
    logic [BYTE_W-1:0]  pixels_left_reg,  pixels_left_next;
    logic [BYTE_W-1:0]  pixel_offset_reg, pixel_offset_next;

    logic in_accept;
    logic launch;
    logic out_free;
    logic job_valid_reg, job_valid_next;
    logic job_final;

    assign out_free  = !out_valid || !out_stall;
    assign in_stall  = job_valid_reg && !(out_free && job_final);
    assign in_accept = in_valid && !in_stall;
    assign launch    = in_accept && (command == CMD_DATA) && (phase_reg == PH_PIX);

    always_comb
    begin
        phase_next        = phase_reg;
        base_column_next  = base_column_reg;
        top_row_next      = top_row_reg;
        screen_sel_next   = screen_sel_reg;
        post_top_next     = post_top_reg;
        pixels_left_next  = pixels_left_reg;
        pixel_offset_next = pixel_offset_reg;

        if (in_accept)
        begin
            if (command == CMD_START)
            begin
                screen_sel_next  = screen_index;
                base_column_next = column_x;
                top_row_next     = column_top_y;
                phase_next       = PH_TOP;
            end
            else
            begin
                case (phase_reg)
                    PH_TOP:
                    begin
                        if (data_byte == END_MARK)
                        begin
                            phase_next = PH_WAIT;
                        end
                        else
                        begin
                            post_top_next = data_byte;
                            phase_next    = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        pixels_left_next  = data_byte;
                        pixel_offset_next = '0;
                        phase_next        = PH_PAD1;
                    end
                    PH_PAD1:
                    begin
                        phase_next = (pixels_left_reg == '0) ? PH_PAD2 : PH_PIX;
                    end
                    PH_PAD2:
                    begin
                        phase_next = PH_TOP;
                    end
                    PH_PIX:
                    begin
                        pixel_offset_next = pixel_offset_reg + BYTE_W'(1);
                        pixels_left_next  = pixels_left_reg - BYTE_W'(1);
                        if (pixels_left_reg == BYTE_W'(1))
                        begin
                            phase_next = PH_PAD2;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_WAIT;
            base_column_reg  <= '0;
            top_row_reg      <= '0;
            screen_sel_reg   <= '0;
            post_top_reg     <= '0;
            pixels_left_reg  <= '0;
            pixel_offset_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            base_column_reg  <= base_column_next;
            top_row_reg      <= top_row_next;
            screen_sel_reg   <= screen_sel_next;
            post_top_reg     <= post_top_next;
            pixels_left_reg  <= pixels_left_next;
            pixel_offset_reg <= pixel_offset_next;
        end
    end

    // First row of the pixel's block.
    logic [SUM_W-1:0] cell_index;
    logic [ROW_W-1:0] row_base;

    assign cell_index = SUM_W'(post_top_reg) + SUM_W'(pixel_offset_reg);
    assign row_base   = ROW_W'(ROW_W'(cell_index) * ROW_W'(eff_scale)) + ROW_W'(top_row_reg);

    // ------------------------------------------------------------------
    // Write generator: one block cell per cycle while the output is free, ys inner, xs outer.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] job_pixel_reg;
    logic [SCR_W-1:0]  job_screen_reg;
    logic [ROW_W-1:0]  job_row_reg;
    logic [COLX_W-1:0] job_col_reg;
    logic [SUB_W-1:0]  job_smax_reg;
    logic [SUB_W-1:0]  xs_reg, xs_next;
    logic [SUB_W-1:0]  ys_reg, ys_next;
    logic              step;

    assign job_final = (xs_reg == job_smax_reg) && (ys_reg == job_smax_reg);
    assign step      = job_valid_reg && out_free;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        if (step)
        begin
            if (ys_reg == job_smax_reg)
            begin
                ys_next = '0;
                xs_next = xs_reg + SUB_W'(1);
                if (xs_reg == job_smax_reg)
                begin
                    job_valid_next = 1'b0;
                end
            end
            else
            begin
                ys_next = ys_reg + SUB_W'(1);
            end
        end
        if (launch)
        begin
            job_valid_next = 1'b1;
            xs_next        = '0;
            ys_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            xs_reg        <= '0;
            ys_reg        <= '0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            xs_reg        <= xs_next;
            ys_reg        <= ys_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            job_pixel_reg  <= data_byte;
            job_screen_reg <= screen_sel_reg;
            job_row_reg    <= row_base;
            job_col_reg    <= base_column_reg;
            job_smax_reg   <= SUB_W'(eff_scale - SCALE_W'(1));
        end
    end

    // Address of the current cell.
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic             cell_oor;
    logic [31:0]      cell_addr;

    assign cell_row  = job_row_reg + ROW_W'(ys_reg);
    assign cell_col  = COL_W'(job_col_reg) + COL_W'(xs_reg);
    assign cell_oor  = (32'(cell_row) >= 32'(SCREEN_HEIGHT)) ||
                       (32'(cell_col) >= 32'(SCREEN_WIDTH));
    assign cell_addr = 32'(cell_row) + 32'(cell_col) * 32'(SCREEN_HEIGHT);

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic               out_valid_reg;
    logic [SCR_W-1:0]   target_screen_reg;
    logic [WADDR_W-1:0] write_address_reg;
    logic [BYTE_W-1:0]  pixel_reg;
    logic               out_of_range_reg;
    logic               last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= job_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            target_screen_reg <= job_screen_reg;
            write_address_reg <= cell_oor ? '0 : cell_addr[WADDR_W-1:0];
            pixel_reg         <= job_pixel_reg;
            out_of_range_reg  <= cell_oor;
            last_reg          <= job_final;
        end
    end

    assign out_valid     = out_valid_reg;
    assign target_screen = target_screen_reg;
    assign write_address = write_address_reg;
    assign pixel         = pixel_reg;
    assign out_of_range  = out_of_range_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

// ===== design/pcpd_checker.sv =====
// ============================================================================
// pcpd_checker: port-level checks of the column post decoder
// Watches the output channel over time; bound to the top level.
// ============================================================================
`default_nettype none

module pcpd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [pcpd_pkg::SCR_W-1:0]    target_screen,
    input wire logic [pcpd_pkg::WADDR_W-1:0]  write_address,
    input wire logic                          out_of_range,
    input wire logic                          last
);
    import pcpd_pkg::*;

    // A result held under stall stays offered.
    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped while stalled");

    // Writes of one pixel block follow each other without a gap.
    a_block_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a pixel block");

    // All writes of one block go to the same screen.
    a_block_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> $stable(target_screen))
        else $error("screen changed inside a pixel block");

    // Off-screen writes carry a zero address.
    a_oor_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> write_address == '0)
        else $error("off-screen write with nonzero address");

endmodule

bind patch_column_post_decoder_unit pcpd_checker u_pcpd_checker (.*);

`default_nettype wire
